// ===== hdl/bresenham_line_rasterizer_macros.svh =====
// Assertion macros shared by the line rasterizer RTL.
`ifndef BRESENHAM_LINE_RASTERIZER_MACROS_SVH
`define BRESENHAM_LINE_RASTERIZER_MACROS_SVH

// Implication checked on every rising clock edge outside of reset.
`define BLR_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Plain invariant, checked on every rising clock edge outside of reset.
`define BLR_ASSERT_ALWAYS(label, expr, msg) \
    `BLR_ASSERT_CLK(label, 1'b1 |-> (expr), msg)

`endif

// ===== hdl/blr_pkg.sv =====
// Shared types and constants of the line rasterizer.
package blr_pkg;

    // Field widths.
    localparam int COORD_W = 6;
    localparam int COLOR_W = 24;
    localparam int DELTA_W = COORD_W + 1;
    localparam int DEC_W   = 10;

    // Tile bound: coordinates at or above it saturate to the tile edge.
    localparam int TILE_SIZE = 64;

    // Depth of the queue of set-up segments between front and walk.
    localparam int QUEUE_DEPTH = 2;

    // Stream data widths, padded to whole bytes.
    localparam int S_TDATA_W = 4 * COORD_W + COLOR_W;
    localparam int M_FIELDS_W = 2 * COORD_W + COLOR_W;
    localparam int M_TDATA_W = ((M_FIELDS_W + 7) / 8) * 8;

    // Octant case that drives the walk.
    typedef enum logic [1:0] {
        OCT_SHALLOW_UP   = 2'd0,
        OCT_STEEP_UP     = 2'd1,
        OCT_SHALLOW_DOWN = 2'd2,
        OCT_STEEP_DOWN   = 2'd3
    } t_octant;

    // One segment after ordering and set-up.
    typedef struct packed {
        logic [COORD_W-1:0]      start_x;
        logic [COORD_W-1:0]      start_y;
        logic [COORD_W-1:0]      stop_x;
        logic [COORD_W-1:0]      stop_y;
        logic signed [DEC_W-1:0] decision;
        logic signed [DEC_W-1:0] delta_a2;
        logic signed [DEC_W-1:0] delta_b2;
        t_octant                 octant;
        logic [COLOR_W-1:0]      color;
    } t_seg;

endpackage

// ===== hdl/blr_front.sv =====
// Front end: takes a segment request, orders the endpoints and sets up the walk.
module blr_front
    import blr_pkg::*;
(
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // start_x[5:0], start_y[11:6], end_x[17:12], end_y[23:18], pen_color[47:24]
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    input  logic                 i_full,
    output logic                 o_push,
    output t_seg                 o_push_data
);

    localparam logic [COORD_W:0]   TILE_LIM = (COORD_W + 1)'(TILE_SIZE);
    localparam logic [COORD_W-1:0] TILE_MAX = COORD_W'(TILE_SIZE - 1);

    logic [COORD_W-1:0]      w_x0, w_y0, w_x1, w_y1;
    logic [COORD_W-1:0]      w_sx, w_sy, w_ex, w_ey;
    logic                    w_swap;
    logic signed [DELTA_W-1:0] w_da, w_db;
    logic signed [DEC_W-1:0] w_da_x, w_db_x;
    logic [COORD_W-1:0]      w_abs_a, w_abs_b;
    logic                    w_rising, w_shallow;

    // Saturate endpoint coordinates to the tile.
    always_comb begin
        w_x0 = ({1'b0, s_axis_tdata[COORD_W-1:0]} >= TILE_LIM)
               ? TILE_MAX : s_axis_tdata[COORD_W-1:0];
        w_y0 = ({1'b0, s_axis_tdata[2*COORD_W-1:COORD_W]} >= TILE_LIM)
               ? TILE_MAX : s_axis_tdata[2*COORD_W-1:COORD_W];
        w_x1 = ({1'b0, s_axis_tdata[3*COORD_W-1:2*COORD_W]} >= TILE_LIM)
               ? TILE_MAX : s_axis_tdata[3*COORD_W-1:2*COORD_W];
        w_y1 = ({1'b0, s_axis_tdata[4*COORD_W-1:3*COORD_W]} >= TILE_LIM)
               ? TILE_MAX : s_axis_tdata[4*COORD_W-1:3*COORD_W];
    end

    // Order the endpoints so that x rises, or y rises when x is equal.
    assign w_swap = (w_x0 > w_x1) || ((w_x0 == w_x1) && (w_y0 > w_y1));
    assign w_sx   = w_swap ? w_x1 : w_x0;
    assign w_sy   = w_swap ? w_y1 : w_y0;
    assign w_ex   = w_swap ? w_x0 : w_x1;
    assign w_ey   = w_swap ? w_y0 : w_y1;

    // Signed deltas and their magnitudes.
    assign w_da    = $signed({1'b0, w_ey}) - $signed({1'b0, w_sy});
    assign w_db    = $signed({1'b0, w_sx}) - $signed({1'b0, w_ex});
    assign w_da_x  = {{(DEC_W - DELTA_W){w_da[DELTA_W-1]}}, w_da};
    assign w_db_x  = {{(DEC_W - DELTA_W){w_db[DELTA_W-1]}}, w_db};
    assign w_abs_a = (w_ey >= w_sy) ? (w_ey - w_sy) : (w_sy - w_ey);
    assign w_abs_b = w_ex - w_sx;

    assign w_rising  = (w_ey >= w_sy) || (w_sx == w_ex);
    assign w_shallow = (w_abs_a <= w_abs_b);

    // Choose the octant case and the starting decision value.
    always_comb begin
        o_push_data.start_x  = w_sx;
        o_push_data.start_y  = w_sy;
        o_push_data.stop_x   = w_ex;
        o_push_data.stop_y   = w_ey;
        o_push_data.delta_a2 = w_da_x + w_da_x;
        o_push_data.delta_b2 = w_db_x + w_db_x;
        o_push_data.color    = s_axis_tdata[S_TDATA_W-1:4*COORD_W];
        unique case ({w_rising, w_shallow})
            2'b11: begin
                o_push_data.octant   = OCT_SHALLOW_UP;
                o_push_data.decision = w_da_x + w_da_x + w_db_x;
            end
            2'b10: begin
                o_push_data.octant   = OCT_STEEP_UP;
                o_push_data.decision = w_da_x + w_db_x + w_db_x;
            end
            2'b01: begin
                o_push_data.octant   = OCT_SHALLOW_DOWN;
                o_push_data.decision = w_da_x + w_da_x - w_db_x;
            end
            default: begin
                o_push_data.octant   = OCT_STEEP_DOWN;
                o_push_data.decision = w_da_x - w_db_x - w_db_x;
            end
        endcase
    end

    // A request is taken whenever the queue has room.
    assign s_axis_tready = !i_full;
    assign o_push        = s_axis_tvalid && !i_full;

endmodule

// ===== hdl/blr_queue.sv =====
// Short queue of set-up segments between the front end and the walk unit.
module blr_queue
    import blr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_seg i_push_data,
    output logic o_full,
    output logic o_valid,
    output t_seg o_data,
    input  logic i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_seg             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// ===== hdl/blr_walk.sv =====
// Walk unit: steps the Bresenham decision variable, one pixel per ready cycle.
module blr_walk
    import blr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  t_seg               i_q_data,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [COORD_W-1:0] o_pixel_x,
    output logic [COORD_W-1:0] o_pixel_y,
    output logic [COLOR_W-1:0] o_pixel_color,
    output logic               o_last_pixel
);

    logic                    r_active, n_active;
    logic [COORD_W-1:0]      r_x, n_x;
    logic [COORD_W-1:0]      r_y, n_y;
    logic [COORD_W-1:0]      r_stop_x, n_stop_x;
    logic [COORD_W-1:0]      r_stop_y, n_stop_y;
    logic signed [DEC_W-1:0] r_dec, n_dec;
    logic signed [DEC_W-1:0] r_da2, n_da2;
    logic signed [DEC_W-1:0] r_db2, n_db2;
    t_octant                 r_oct, n_oct;
    logic [COLOR_W-1:0]      r_color, n_color;

    logic                    w_last, w_accept, w_minor;
    logic signed [DEC_W-1:0] w_major_term, w_minor_term;
    logic [COORD_W-1:0]      w_step_x, w_step_y;

    // Current pixel straight from the walk registers.
    assign o_valid       = r_active;
    assign o_pixel_x     = r_x;
    assign o_pixel_y     = r_y;
    assign o_pixel_color = r_color;
    assign o_last_pixel  = w_last;

    assign w_last = ((r_oct == OCT_SHALLOW_UP) || (r_oct == OCT_SHALLOW_DOWN))
                    ? (r_x == r_stop_x) : (r_y == r_stop_y);
    assign w_accept = r_active && i_ready;

    // Load the next segment when idle or as the last pixel leaves.
    assign o_pop = i_q_valid && (!r_active || (w_accept && w_last));

    // One Bresenham step for the current octant case.
    always_comb begin
        unique case (r_oct)
            OCT_SHALLOW_UP: begin
                w_minor      = (r_dec > 0);
                w_major_term = r_da2;
                w_minor_term = r_db2;
                w_step_x     = r_x + 1'b1;
                w_step_y     = w_minor ? r_y + 1'b1 : r_y;
            end
            OCT_STEEP_UP: begin
                w_minor      = (r_dec < 0);
                w_major_term = r_db2;
                w_minor_term = r_da2;
                w_step_x     = w_minor ? r_x + 1'b1 : r_x;
                w_step_y     = r_y + 1'b1;
            end
            OCT_SHALLOW_DOWN: begin
                w_minor      = (r_dec < 0);
                w_major_term = r_da2;
                w_minor_term = -r_db2;
                w_step_x     = r_x + 1'b1;
                w_step_y     = w_minor ? r_y - 1'b1 : r_y;
            end
            default: begin
                w_minor      = (r_dec > 0);
                w_major_term = -r_db2;
                w_minor_term = r_da2;
                w_step_x     = w_minor ? r_x + 1'b1 : r_x;
                w_step_y     = r_y - 1'b1;
            end
        endcase
    end

    // Next walk state: load, step, go idle or hold.
    always_comb begin
        n_active = r_active;
        n_x      = r_x;
        n_y      = r_y;
        n_stop_x = r_stop_x;
        n_stop_y = r_stop_y;
        n_dec    = r_dec;
        n_da2    = r_da2;
        n_db2    = r_db2;
        n_oct    = r_oct;
        n_color  = r_color;
        if (o_pop) begin
            n_active = 1'b1;
            n_x      = i_q_data.start_x;
            n_y      = i_q_data.start_y;
            n_stop_x = i_q_data.stop_x;
            n_stop_y = i_q_data.stop_y;
            n_dec    = i_q_data.decision;
            n_da2    = i_q_data.delta_a2;
            n_db2    = i_q_data.delta_b2;
            n_oct    = i_q_data.octant;
            n_color  = i_q_data.color;
        end else if (w_accept) begin
            if (w_last) begin
                n_active = 1'b0;
            end else begin
                n_x   = w_step_x;
                n_y   = w_step_y;
                n_dec = r_dec + w_major_term + (w_minor ? w_minor_term : '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else begin
            r_active <= n_active;
        end
    end

    // Walk payload registers.
    always_ff @(posedge i_clk) begin
        r_x      <= n_x;
        r_y      <= n_y;
        r_stop_x <= n_stop_x;
        r_stop_y <= n_stop_y;
        r_dec    <= n_dec;
        r_da2    <= n_da2;
        r_db2    <= n_db2;
        r_oct    <= n_oct;
        r_color  <= n_color;
    end

endmodule

// ===== hdl/bresenham_line_rasterizer.sv =====
// Line rasterizer top level: one segment request in, one pixel request per plotted point out.
// A taken segment is written into the queue, then loaded into the walk registers, from which
// its first pixel is shown when the walk unit is free. Two set-up segments queue.
// Throughput: one pixel per cycle while m_axis_tready is high, set by the single decision
// update per cycle in the walk unit; a segment has max(|dx|,|dy|)+1 pixels (1 to 64).
// Reset: synchronous, active low; it empties the queue and leaves the walk unit idle.
module bresenham_line_rasterizer
    import blr_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // start_x[5:0], start_y[11:6], end_x[17:12], end_y[23:18], pen_color[47:24]
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // pixel_x[5:0], pixel_y[11:6], pixel_color[35:12], zero pad above
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // last_pixel
    output logic                 m_axis_tlast
);

`include "bresenham_line_rasterizer_macros.svh"

    logic               w_push, w_full, w_q_valid, w_pop;
    t_seg               w_push_data, w_q_data;
    logic [COORD_W-1:0] w_px, w_py;
    logic [COLOR_W-1:0] w_pcolor;

    // Set-up of incoming segments.
    blr_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_full        (w_full),
        .o_push        (w_push),
        .o_push_data   (w_push_data)
    );

    // Queue between set-up and walk.
    blr_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .o_full      (w_full),
        .o_valid     (w_q_valid),
        .o_data      (w_q_data),
        .i_pop       (w_pop)
    );

    // Pixel walk.
    blr_walk u_walk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .i_q_data      (w_q_data),
        .o_pop         (w_pop),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_pixel_x     (w_px),
        .o_pixel_y     (w_py),
        .o_pixel_color (w_pcolor),
        .o_last_pixel  (m_axis_tlast)
    );

    // Pack the pixel fields, zero-padded to whole bytes.
    assign m_axis_tdata = M_TDATA_W'({w_pcolor, w_py, w_px});

    // A full queue always holds a segment for the walk unit.
    `BLR_ASSERT_ALWAYS(a_full_has_seg, s_axis_tready || w_q_valid, "Queue full but empty")

    // A segment is walked without gaps until its last pixel.
    `BLR_ASSERT_CLK(a_walk_no_gap, m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid, "Gap inside a segment")

    // Within a segment, x never falls and rises by at most one per pixel.
    `BLR_ASSERT_CLK(a_x_step, m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> (m_axis_tdata[5:0] == $past(m_axis_tdata[5:0])) || (m_axis_tdata[5:0] == $past(m_axis_tdata[5:0]) + 6'd1), "Bad x step")

endmodule

// ===== test/bresenham_line_rasterizer_tb.sv =====
// Self-checking testbench for the line rasterizer: directed segments, then random ones.
module bresenham_line_rasterizer_tb;
    import blr_pkg::*;

    // One plotted pixel as it should leave the block.
    typedef struct {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COLOR_W-1:0] color;
        logic               last;
    } t_pixel;

    // One row of the directed table. A typed row carries its single expected pixel.
    typedef struct {
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] y0;
        logic [COORD_W-1:0] x1;
        logic [COORD_W-1:0] y1;
        logic [COLOR_W-1:0] color;
        bit                 typed;
        logic [COORD_W-1:0] ex;
        logic [COORD_W-1:0] ey;
    } t_segment_row;

    localparam int NUM_ROWS      = 21;
    localparam int NUM_RANDOM    = 200;
    localparam int STALL_LIMIT   = 5000;
    localparam int DRAIN_CYCLES  = 70;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // start_x[5:0], start_y[11:6], end_x[17:12], end_y[23:18], pen_color[47:24]
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // pixel_x[5:0], pixel_y[11:6], pixel_color[35:12], zero pad above
    logic [M_TDATA_W-1:0] m_axis_tdata;
    // last_pixel
    logic                 m_axis_tlast;

    t_pixel       pixel_queue[$];
    t_segment_row segment_table[NUM_ROWS];
    int           mismatch_count = 0;
    int           stall_cycles = 0;
    bit           calm = 1'b0;

    bresenham_line_rasterizer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 i_clk = ~i_clk;

    // Walk one segment and queue every pixel it should produce.
    task automatic trace_segment(input logic [COORD_W-1:0] ax, input logic [COORD_W-1:0] ay,
                                 input logic [COORD_W-1:0] bx, input logic [COORD_W-1:0] by,
                                 input logic [COLOR_W-1:0] color);
        logic [COORD_W-1:0] x0, y0, x1, y1, swap, cx, cy;
        int                 da, db, dec, mag_a, mag_b, n;
        t_octant            oct;
        logic               last;
        t_pixel             p;
        // Six-bit coordinates always lie inside a 64-wide tile, so no saturation applies.
        x0 = ax; y0 = ay; x1 = bx; y1 = by;
        // Order the endpoints so that x rises, or y rises on a vertical line.
        if (x0 > x1) begin
            swap = x0; x0 = x1; x1 = swap;
            swap = y0; y0 = y1; y1 = swap;
        end else if (x0 == x1 && y0 > y1) begin
            swap = y0; y0 = y1; y1 = swap;
        end
        da = int'(y1) - int'(y0);
        db = int'(x0) - int'(x1);
        mag_a = (da < 0) ? -da : da;
        mag_b = (db < 0) ? -db : db;
        // Pick the octant case and its starting decision value.
        if (da >= 0 || db == 0) begin
            if (mag_a <= mag_b) begin
                oct = OCT_SHALLOW_UP;   dec = 2 * da + db;
            end else begin
                oct = OCT_STEEP_UP;     dec = da + 2 * db;
            end
        end else begin
            if (mag_a <= mag_b) begin
                oct = OCT_SHALLOW_DOWN; dec = 2 * da - db;
            end else begin
                oct = OCT_STEEP_DOWN;   dec = da - 2 * db;
            end
        end
        cx = x0;
        cy = y0;
        for (n = 0; n < 64; n++) begin
            last = (oct == OCT_SHALLOW_UP || oct == OCT_SHALLOW_DOWN) ? (cx == x1) : (cy == y1);
            p.x = cx; p.y = cy; p.color = color; p.last = last;
            pixel_queue.push_back(p);
            if (last) break;
            // A decision of exactly zero never moves the minor axis.
            case (oct)
                OCT_SHALLOW_UP: begin
                    if (dec > 0) begin cy = cy + 1'b1; dec += 2 * db; end
                    cx = cx + 1'b1; dec += 2 * da;
                end
                OCT_STEEP_UP: begin
                    if (dec < 0) begin cx = cx + 1'b1; dec += 2 * da; end
                    cy = cy + 1'b1; dec += 2 * db;
                end
                OCT_SHALLOW_DOWN: begin
                    if (dec < 0) begin cy = cy - 1'b1; dec -= 2 * db; end
                    cx = cx + 1'b1; dec += 2 * da;
                end
                default: begin
                    if (dec > 0) begin cx = cx + 1'b1; dec += 2 * da; end
                    cy = cy - 1'b1; dec -= 2 * db;
                end
            endcase
        end
    endtask

    // Offer one segment request, with random gaps unless calm, and wait until it is taken.
    task automatic send_segment(input logic [COORD_W-1:0] x0, input logic [COORD_W-1:0] y0,
                                input logic [COORD_W-1:0] x1, input logic [COORD_W-1:0] y1,
                                input logic [COLOR_W-1:0] color);
        while (!calm && $urandom_range(99) < 38) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tdata  <= {color, y1, x1, y0, x0};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Stop offering requests and hold off until every queued pixel has arrived.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pixel_queue.size() != 0) @(posedge i_clk);
    endtask

    // Receiver side: random back-pressure except during the calm stretch.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= calm || ($urandom_range(99) >= 38);
        end
    end

    // Compare each accepted pixel with the oldest expectation.
    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pixel_queue.size() == 0) begin
                $error("unexpected pixel: x=%0d y=%0d", m_axis_tdata[5:0], m_axis_tdata[11:6]);
                mismatch_count++;
            end else begin
                want = pixel_queue.pop_front();
                if (m_axis_tdata[5:0] !== want.x) begin
                    $error("pixel_x: expected %0d, got %0d", want.x, m_axis_tdata[5:0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[11:6] !== want.y) begin
                    $error("pixel_y: expected %0d, got %0d", want.y, m_axis_tdata[11:6]);
                    mismatch_count++;
                end
                if (m_axis_tdata[35:12] !== want.color) begin
                    $error("pixel_color: expected %h, got %h", want.color, m_axis_tdata[35:12]);
                    mismatch_count++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last_pixel: expected %0d, got %0d", want.last, m_axis_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: too long without any request moving on either side ends the run.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Stimulus.
    initial begin
        t_pixel             p;
        logic [COORD_W-1:0] x0, y0, x1, y1;
        logic [COLOR_W-1:0] color;
        int                 k;

        // Single points, extremes, all four octants, swaps and decision ties.
        segment_table = '{
            '{6'd0,  6'd0,  6'd0,  6'd0,  24'h000000, 1'b1, 6'd0,  6'd0 },
            '{6'd63, 6'd63, 6'd63, 6'd63, 24'hFFFFFF, 1'b1, 6'd63, 6'd63},
            '{6'd21, 6'd42, 6'd21, 6'd42, 24'hA5A5A5, 1'b1, 6'd21, 6'd42},
            '{6'd0,  6'd0,  6'd63, 6'd0,  24'hFF0000, 1'b0, 6'd0,  6'd0 },
            '{6'd63, 6'd5,  6'd0,  6'd5,  24'h00FF00, 1'b0, 6'd0,  6'd0 },
            '{6'd10, 6'd0,  6'd10, 6'd63, 24'h0000FF, 1'b0, 6'd0,  6'd0 },
            '{6'd10, 6'd63, 6'd10, 6'd0,  24'h123456, 1'b0, 6'd0,  6'd0 },
            '{6'd0,  6'd0,  6'd63, 6'd63, 24'h654321, 1'b0, 6'd0,  6'd0 },
            '{6'd0,  6'd63, 6'd63, 6'd0,  24'hABCDEF, 1'b0, 6'd0,  6'd0 },
            '{6'd63, 6'd0,  6'd0,  6'd63, 24'hFEDCBA, 1'b0, 6'd0,  6'd0 },
            '{6'd2,  6'd3,  6'd12, 6'd7,  24'h5A5A5A, 1'b0, 6'd0,  6'd0 },
            '{6'd4,  6'd1,  6'd9,  6'd30, 24'hC3C3C3, 1'b0, 6'd0,  6'd0 },
            '{6'd3,  6'd20, 6'd40, 6'd8,  24'h3C3C3C, 1'b0, 6'd0,  6'd0 },
            '{6'd30, 6'd50, 6'd35, 6'd2,  24'h0F0F0F, 1'b0, 6'd0,  6'd0 },
            '{6'd0,  6'd0,  6'd2,  6'd1,  24'hF0F0F0, 1'b0, 6'd0,  6'd0 },
            '{6'd0,  6'd0,  6'd1,  6'd2,  24'h111111, 1'b0, 6'd0,  6'd0 },
            '{6'd0,  6'd1,  6'd2,  6'd0,  24'h222222, 1'b0, 6'd0,  6'd0 },
            '{6'd0,  6'd2,  6'd1,  6'd0,  24'h333333, 1'b0, 6'd0,  6'd0 },
            '{6'd63, 6'd62, 6'd0,  6'd0,  24'h444444, 1'b0, 6'd0,  6'd0 },
            '{6'd50, 6'd10, 6'd51, 6'd11, 24'h555555, 1'b0, 6'd0,  6'd0 },
            '{6'd0,  6'd63, 6'd0,  6'd0,  24'h666666, 1'b0, 6'd0,  6'd0 }
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: typed rows expect their own single pixel.
        foreach (segment_table[r]) begin
            send_segment(segment_table[r].x0, segment_table[r].y0,
                         segment_table[r].x1, segment_table[r].y1, segment_table[r].color);
            if (segment_table[r].typed) begin
                p.x = segment_table[r].ex; p.y = segment_table[r].ey;
                p.color = segment_table[r].color; p.last = 1'b1;
                pixel_queue.push_back(p);
            end else begin
                trace_segment(segment_table[r].x0, segment_table[r].y0,
                              segment_table[r].x1, segment_table[r].y1, segment_table[r].color);
            end
        end
        wait_drained();

        // Random part: mostly short segments, some axis-aligned or points, some full range.
        for (int i = 0; i < NUM_RANDOM; i++) begin
            if (i == 100) wait_drained();
            calm = (i >= 120 && i < 160);
            k = int'($urandom_range(99));
            x0 = COORD_W'($urandom);
            y0 = COORD_W'($urandom);
            if (k < 55) begin
                x1 = COORD_W'(x0 + $urandom_range(14) - 7);
                y1 = COORD_W'(y0 + $urandom_range(14) - 7);
            end else if (k < 70) begin
                x1 = ($urandom_range(1)) ? x0 : COORD_W'($urandom);
                y1 = ($urandom_range(1)) ? y0 : COORD_W'($urandom);
            end else begin
                x1 = COORD_W'($urandom);
                y1 = COORD_W'($urandom);
            end
            color = COLOR_W'($urandom);
            send_segment(x0, y0, x1, y1, color);
            trace_segment(x0, y0, x1, y1, color);
        end
        calm = 1'b0;

        // Let everything drain, then watch a little longer for stray pixels.
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pixel_queue.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/blr_pkg.sv
hdl/blr_front.sv
hdl/blr_queue.sv
hdl/blr_walk.sv
hdl/bresenham_line_rasterizer.sv
test/bresenham_line_rasterizer_tb.sv
